/* rtl/core/smau_pkg.sv */
package smau_pkg;

	// Operation register codes
	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_NEG   = 3'd2;
	localparam logic [2:0] OP_SCALE = 3'd3;
	localparam logic [2:0] OP_MMUL  = 3'd4;
	localparam logic [2:0] OP_MVEC  = 3'd5;

	// Command codes of an input item
	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_RUN    = 2'd2;

	// Register indexes on the APB port (byte address = 4 * index)
	localparam logic [2:0] REG_OPERATION = 3'd0;
	localparam logic [2:0] REG_ROWS_A    = 3'd1;
	localparam logic [2:0] REG_COLS_A    = 3'd2;
	localparam logic [2:0] REG_COLS_B    = 3'd3;
	localparam logic [2:0] REG_SCALE     = 3'd4;

	localparam int FRAC_BITS  = 16;
	localparam int RESULT_CAP = 16;
	localparam int CNT_W      = $clog2(RESULT_CAP);

	// Sequencer controls for the arithmetic unit
	typedef struct packed {
		logic load_term;  // register product / sum of the operands
		logic acc_en;     // add the term into the accumulator
		logic acc_clr;    // clear the accumulator
	} alu_ctrl_t;

endpackage

/* rtl/core/smau_ram.sv */
module smau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/smau_alu.sv */
module smau_alu #(
	parameter int MAX_DIM = 4
) (
	input  logic                    clk,
	input  smau_pkg::alu_ctrl_t     ctrl,
	input  logic [2:0]              operation,
	input  logic signed [31:0]      a_data,
	input  logic signed [31:0]      b_data,
	input  logic signed [31:0]      scale_factor,
	output logic signed [31:0]      result
);
	import smau_pkg::*;

	// exact sum of up to MAX_DIM Q32.32 products, plus headroom
	localparam int ACC_W = 66 + $clog2(MAX_DIM);

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

	logic signed [31:0]      mul_b;
	logic signed [63:0]      product;
	logic signed [63:0]      term_d;
	logic signed [63:0]      term_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] scaled;
	logic                    floor_en;

	// shared multiplier: B operand or the scale constant
	assign mul_b   = (operation == OP_SCALE) ? scale_factor : b_data;
	assign product = a_data * mul_b;

	always_comb begin
		case (operation)
			OP_ADD:  term_d = 64'(a_data) + 64'(b_data);
			OP_SUB:  term_d = 64'(a_data) - 64'(b_data);
			OP_NEG:  term_d = -64'(a_data);
			default: term_d = product;
		endcase
	end

	// term register, then exact accumulation
	always_ff @(posedge clk) begin
		if (ctrl.load_term) begin
			term_q <= term_d;
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ACC_W'(term_q);
		end
	end

	// products drop the fraction by flooring, then saturate to Q16.16
	assign floor_en = (operation == OP_SCALE) || (operation == OP_MMUL) ||
	                  (operation == OP_MVEC);
	assign scaled   = floor_en ? (acc_q >>> FRAC_BITS) : acc_q;

	always_comb begin
		if (scaled > SAT_HI) begin
			result = 32'sh7FFF_FFFF;
		end else if (scaled < SAT_LO) begin
			result = 32'sh8000_0000;
		end else begin
			result = scaled[31:0];
		end
	end

endmodule

/* rtl/core/small_matrix_arithmetic_unit.sv */
// Small matrix arithmetic unit: add, subtract, negate, scale, matrix product and
// matrix-vector product on Q16.16 matrices of up to MAX_DIM x MAX_DIM.
// Command channel: an item is taken when start is high and busy is low.
//   Load A / load B items write one element; busy stays low, so loads can be
//   issued back to back. Loads outside the configured shape are dropped. A run
//   item with a valid operation starts the sequencer and holds busy to its end.
// Results: each element appears for one cycle with result_valid high, in
//   row-major order; last_element marks the final one. The receiver cannot
//   stall the block.
// Run sequence: every element goes through the shared term register and
//   accumulator. Element-wise operations step through RAM read, term, add and
//   output; products repeat read, term and add per column of A, then output.
//   Busy drops in the cycle the last strobe is raised.
// Configuration is an APB port (5 registers, 4-byte stride), written only while
//   the block is idle: a rule for the user that the block does not enforce. Reset
//   restores the register defaults and idles the sequencer; the matrix stores
//   are not cleared and must be loaded before use.
module small_matrix_arithmetic_unit #(
	parameter int MAX_DIM = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [1:0]         row_index,
	input  logic [1:0]         col_index,
	input  logic signed [31:0] element_value,
	// result channel
	output logic               result_valid,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic signed [31:0] out_value,
	output logic               last_element,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import smau_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_MUL  = 5'b00100,
		S_ACC  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [2:0] r);
		if (r == 3'd0) begin
			return DIM_W'(1);
		end else if (int'(r) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end else begin
			return DIM_W'(r);
		end
	endfunction

	function automatic logic [ADDR_W-1:0] elem_addr(input int r, input int c);
		return ADDR_W'(r * MAX_DIM + c);
	endfunction

	state_t                  state_q;
	logic [2:0]              operation_q;
	logic [2:0]              rows_a_q;
	logic [2:0]              cols_a_q;
	logic [2:0]              cols_b_q;
	logic signed [31:0]      scale_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        k_q;
	logic [CNT_W-1:0]        n_q;
	logic                    valid_q;
	logic                    last_q;
	logic [1:0]              row_q;
	logic [1:0]              col_q;
	logic signed [31:0]      value_q;

	logic [DIM_W-1:0]        ra, ca, cb, nc, br, bc;
	logic                    is_dot, is_vec;
	logic                    accept, cfg_wr;
	logic                    load_in_a, load_in_b, run_ok;
	logic                    we_a, we_b;
	logic [ADDR_W-1:0]       waddr;
	logic [ADDR_W-1:0]       raddr_a, raddr_b;
	logic signed [31:0]      rdata_a, rdata_b;
	logic signed [31:0]      alu_result;
	logic                    k_last, j_last, i_last, elem_last;
	alu_ctrl_t               alu_ctrl;

	// effective sizes
	assign ra     = clamp_dim(rows_a_q);
	assign ca     = clamp_dim(cols_a_q);
	assign cb     = clamp_dim(cols_b_q);
	assign is_dot = (operation_q == OP_MMUL) || (operation_q == OP_MVEC);
	assign is_vec = (operation_q == OP_MVEC);
	assign nc     = (operation_q == OP_MMUL) ? cb :
	                (operation_q == OP_MVEC) ? DIM_W'(1) : ca;
	// shape of B that the current operation reads
	assign br     = is_dot ? ca : ra;
	assign bc     = (operation_q == OP_MMUL) ? cb :
	                (operation_q == OP_MVEC) ? DIM_W'(1) : ca;

	// command decode
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign load_in_a = (DIM_W'(row_index) < ra) && (DIM_W'(col_index) < ca);
	assign load_in_b = (DIM_W'(row_index) < br) && (DIM_W'(col_index) < bc);
	assign we_a      = accept && (opcode == CMD_LOAD_A) && load_in_a;
	assign we_b      = accept && (opcode == CMD_LOAD_B) && load_in_b;
	assign run_ok    = accept && (opcode == CMD_RUN) && (operation_q <= OP_MVEC);
	assign waddr     = elem_addr(int'(row_index), int'(col_index));

	// operand addresses from the loop counters
	assign raddr_a = is_dot ? elem_addr(int'(i_q), int'(k_q)) :
	                 elem_addr(int'(i_q), int'(j_q));
	assign raddr_b = !is_dot ? elem_addr(int'(i_q), int'(j_q)) :
	                 is_vec  ? elem_addr(int'(k_q), 0) : elem_addr(int'(k_q), int'(j_q));

	smau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (element_value),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	smau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (element_value),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// arithmetic unit controls
	always_comb begin
		alu_ctrl.load_term = (state_q == S_MUL);
		alu_ctrl.acc_en    = (state_q == S_ACC);
		alu_ctrl.acc_clr   = run_ok || (state_q == S_OUT);
	end

	smau_alu #(.MAX_DIM(MAX_DIM)) u_alu (
		.clk          (clk),
		.ctrl         (alu_ctrl),
		.operation    (operation_q),
		.a_data       (rdata_a),
		.b_data       (rdata_b),
		.scale_factor (scale_q),
		.result       (alu_result)
	);

	// loop ends
	assign k_last    = !is_dot || (DIM_W'(k_q) == ca - DIM_W'(1));
	assign j_last    = (DIM_W'(j_q) == nc - DIM_W'(1));
	assign i_last    = (DIM_W'(i_q) == ra - DIM_W'(1));
	assign elem_last = (j_last && i_last) || (n_q == CNT_W'(RESULT_CAP - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (run_ok) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						n_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (k_last) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					k_q <= '0;
					n_q <= n_q + CNT_W'(1);
					if (elem_last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
						if (j_last) begin
							j_q <= '0;
							i_q <= i_q + IDX_W'(1);
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= (state_q == S_OUT);
			last_q  <= (state_q == S_OUT) && elem_last;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			row_q   <= 2'(i_q);
			col_q   <= 2'(j_q);
			value_q <= alu_result;
		end
	end

	assign result_valid = valid_q;
	assign last_element = last_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign out_value    = value_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q <= OP_ADD;
			rows_a_q    <= 3'd4;
			cols_a_q    <= 3'd4;
			cols_b_q    <= 3'd4;
			scale_q     <= 32'sd65536;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_OPERATION: operation_q <= pwdata[2:0];
				REG_ROWS_A:    rows_a_q    <= pwdata[2:0];
				REG_COLS_A:    cols_a_q    <= pwdata[2:0];
				REG_COLS_B:    cols_b_q    <= pwdata[2:0];
				REG_SCALE:     scale_q     <= pwdata;
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_OPERATION: prdata = {29'd0, operation_q};
			REG_ROWS_A:    prdata = {29'd0, rows_a_q};
			REG_COLS_A:    prdata = {29'd0, cols_a_q};
			REG_COLS_B:    prdata = {29'd0, cols_b_q};
			REG_SCALE:     prdata = scale_q;
			default:       prdata = 32'd0;
		endcase
	end

	// checks
	a_strobe_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_OUT))
		else $error("result strobe without an output step");

	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_element |-> result_valid)
		else $error("last flag without a result");

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_ok |=> busy)
		else $error("accepted run did not start the sequencer");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_element) |-> busy)
		else $error("sequencer idled before the last result");

endmodule
